>>> rtl/bollinger_band_reversion_signal_assert.svh
// ============================================================================
// Assertion macros for the Bollinger band reversion signal
// Shared property forms for the checker, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef BOLLINGER_BAND_REVERSION_SIGNAL_ASSERT_SVH
`define BOLLINGER_BAND_REVERSION_SIGNAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bbrs_pkg.sv
// ============================================================================
// Bollinger band reversion signal package
// Widths, codes, sequencer states and shared types for the block.
// ============================================================================
`default_nettype none

package bbrs_pkg;

    // Window geometry.
    localparam int MAX_WINDOW = 64;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int MIN_WINDOW = 2;

    // Data path widths.
    localparam int PRICE_W = 24;
    localparam int SUM_W   = 30;
    localparam int SQ_W    = 2 * PRICE_W + PTR_W;
    localparam int VAR_W   = SQ_W + LEN_W;
    localparam int K_W     = 12;
    localparam int K2_W    = 2 * K_W;
    localparam int MAG2_W  = 2 * SUM_W;
    localparam int KSHIFT  = 16;
    localparam int RHS_W   = K2_W + VAR_W;
    localparam int ACT_W   = 2;
    localparam int CFG_W   = 12;

    // Shared multiplier.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Reset values of the registers.
    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(14);
    localparam logic [K_W-1:0]   BAND_WIDTH_K_RESET  = K_W'(512);

    typedef logic [MUL_W-1:0]   t_mul_op;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [SQ_W-1:0]    t_sq;
    typedef logic [VAR_W-1:0]   t_var;
    typedef logic [RHS_W-1:0]   t_rhs;
    typedef logic [LEN_W-1:0]   t_len;

    // Register indexes of the configuration port.
    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_BAND_WIDTH_K  = 1'b1
    } t_cfg_index;

    // Action codes of a result word.
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_ENTER = 2'd1,
        ACT_EXIT  = 2'd2
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_OLD,
        S_NEW,
        S_SQ,
        S_NQL,
        S_NQH,
        S_NP,
        S_VAR,
        S_MAG,
        S_M2,
        S_KVL,
        S_KVH,
        S_SUM,
        S_DEC
    } t_state;

    // Commands from the sequencer to the price ring.
    typedef struct packed {
        logic clear;
        logic rd;
        logic adv;
    } t_ring_ctrl;

    // Status of the price ring.
    typedef struct packed {
        logic was_full;
        logic full;
    } t_ring_stat;

endpackage

`default_nettype wire

>>> rtl/bbrs_mul.sv
// ============================================================================
// Shared multiplier
// One unsigned 32 by 32 multiplier with a registered product, reused for
// every product of an item under control of the sequencer.
// ============================================================================
`default_nettype none

module bbrs_mul (
    input  wire                   i_clk,
    input  wire bbrs_pkg::t_mul_op i_a,
    input  wire bbrs_pkg::t_mul_op i_b,
    output bbrs_pkg::t_prod       o_p
);

    bbrs_pkg::t_prod r_p;

    // Product is registered and ready in the cycle after the operands are presented.
    always_ff @(posedge i_clk) begin
        r_p <= bbrs_pkg::PROD_W'(i_a) * bbrs_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> rtl/bbrs_ring.sv
// ============================================================================
// Price ring
// Holds the last window_length prices with its write pointer and fill count.
// The oldest price is read in the accept cycle and replaced in the cycle after it.
// ============================================================================
`default_nettype none

module bbrs_ring (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire bbrs_pkg::t_ring_ctrl          i_ctrl,
    input  wire bbrs_pkg::t_len                i_len,
    input  wire [bbrs_pkg::PRICE_W-1:0]        i_price,
    output logic [bbrs_pkg::PRICE_W-1:0]       o_rdata,
    output bbrs_pkg::t_ring_stat               o_stat
);

    logic [bbrs_pkg::PRICE_W-1:0] r_mem [bbrs_pkg::MAX_WINDOW];
    logic [bbrs_pkg::PRICE_W-1:0] r_rdata;
    logic [bbrs_pkg::PTR_W-1:0]   r_wp;
    logic [bbrs_pkg::PTR_W-1:0]   n_wp;
    bbrs_pkg::t_len               r_fill;
    bbrs_pkg::t_len               n_fill;
    logic [bbrs_pkg::PTR_W-1:0]   wp_eff;
    bbrs_pkg::t_len               wp_inc;
    logic                         was_full;

    // A pointer left beyond a shorter window wraps to the start.
    always_comb begin
        wp_eff   = (bbrs_pkg::LEN_W'(r_wp) >= i_len) ? '0 : r_wp;
        wp_inc   = bbrs_pkg::LEN_W'(wp_eff) + bbrs_pkg::LEN_W'(1);
        was_full = (r_fill >= i_len);
        n_wp     = (wp_inc >= i_len) ? '0 : wp_inc[bbrs_pkg::PTR_W-1:0];
        n_fill   = was_full ? i_len : r_fill + bbrs_pkg::LEN_W'(1);
    end

    // Memory: registered read of the oldest entry, write of the new price.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_rdata <= r_mem[wp_eff];
        end
        if (i_ctrl.adv) begin
            r_mem[wp_eff] <= i_price;
        end
    end

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_ctrl.adv) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    assign o_rdata         = r_rdata;
    assign o_stat.was_full = was_full;
    assign o_stat.full     = (r_fill == i_len);

endmodule

`default_nettype wire

>>> rtl/bollinger_band_reversion_signal.sv
// ============================================================================
// Bollinger band reversion signal
// Sliding-window mean and deviation band test that gives enter and exit
// actions for a stream of prices.
// ============================================================================
// One price word is taken when the block is idle; the sequencer then steps
// through S_OLD to S_DEC and loads its result word once the output register is
// free, and the next price is taken only back in idle. The steps are set
// by the single 32 by 32 multiplier, which computes all ten products of an
// item one after another (squares of the old and new price, the squared sum,
// the window length times the square sum in two halves, the window length
// times the price, k squared, the squared deviation and k squared times the
// variance in two halves). A finished word waits in the output register while
// the next price is taken. Writing window_length empties the window; no
// action is given until it holds window_length prices again.
// ============================================================================
`default_nettype none

module bollinger_band_reversion_signal (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_index,
    input  wire [bbrs_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire [bbrs_pkg::PRICE_W-1:0]       i_price_sample,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [bbrs_pkg::ACT_W-1:0]        o_action,
    output logic                              o_window_full,
    output logic                              o_position_held,
    output logic [bbrs_pkg::SUM_W-1:0]        o_window_total
);

    bbrs_pkg::t_state             r_state;
    bbrs_pkg::t_state             n_state;
    bbrs_pkg::t_len               r_len;
    logic [bbrs_pkg::K_W-1:0]     r_k;
    logic [bbrs_pkg::PRICE_W-1:0] r_price;
    bbrs_pkg::t_sum               r_sum;
    bbrs_pkg::t_sq                r_sq;
    bbrs_pkg::t_var               r_ss;
    bbrs_pkg::t_var               r_var;
    bbrs_pkg::t_sum               r_np;
    bbrs_pkg::t_sum               r_mag;
    logic                         r_above;
    logic                         r_below;
    logic [bbrs_pkg::K2_W-1:0]    r_k2;
    logic [bbrs_pkg::MAG2_W-1:0]  r_lhs;
    bbrs_pkg::t_rhs               r_rhs;
    logic                         r_was_full;
    logic                         r_holding;
    logic                         r_out_valid;
    bbrs_pkg::t_action            r_action;
    logic                         r_out_full;
    logic                         r_out_held;
    bbrs_pkg::t_sum               r_out_total;

    bbrs_pkg::t_mul_op            mul_a;
    bbrs_pkg::t_mul_op            mul_b;
    bbrs_pkg::t_prod              mul_p;
    bbrs_pkg::t_ring_ctrl         ring_ctrl;
    bbrs_pkg::t_ring_stat         ring_stat;
    logic [bbrs_pkg::PRICE_W-1:0] ring_rdata;
    logic                         accept;
    logic                         out_free;
    logic                         load_out;
    logic                         beyond;
    bbrs_pkg::t_action            act;
    logic                         n_holding;
    bbrs_pkg::t_len               len_clamped;

    // Shared multiplier.
    bbrs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Price ring with pointer and fill count.
    bbrs_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ring_ctrl),
        .i_len   (r_len),
        .i_price (r_price),
        .o_rdata (ring_rdata),
        .o_stat  (ring_stat)
    );

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // The low seven bits of a window length write are clamped to the legal span.
    always_comb begin
        len_clamped = i_cfg_data[bbrs_pkg::LEN_W-1:0];
        if (len_clamped < bbrs_pkg::LEN_W'(bbrs_pkg::MIN_WINDOW)) begin
            len_clamped = bbrs_pkg::LEN_W'(bbrs_pkg::MIN_WINDOW);
        end else if (len_clamped > bbrs_pkg::LEN_W'(bbrs_pkg::MAX_WINDOW)) begin
            len_clamped = bbrs_pkg::LEN_W'(bbrs_pkg::MAX_WINDOW);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= bbrs_pkg::WINDOW_LENGTH_RESET;
            r_k   <= bbrs_pkg::BAND_WIDTH_K_RESET;
        end else if (i_cfg_we) begin
            unique case (bbrs_pkg::t_cfg_index'(i_cfg_index))
                bbrs_pkg::CFG_WINDOW_LENGTH: r_len <= len_clamped;
                bbrs_pkg::CFG_BAND_WIDTH_K:  r_k   <= i_cfg_data[bbrs_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbrs_pkg::S_IDLE: if (i_valid) n_state = bbrs_pkg::S_OLD;
            bbrs_pkg::S_OLD:  n_state = bbrs_pkg::S_NEW;
            bbrs_pkg::S_NEW:  n_state = bbrs_pkg::S_SQ;
            bbrs_pkg::S_SQ:   n_state = bbrs_pkg::S_NQL;
            bbrs_pkg::S_NQL:  n_state = bbrs_pkg::S_NQH;
            bbrs_pkg::S_NQH:  n_state = bbrs_pkg::S_NP;
            bbrs_pkg::S_NP:   n_state = bbrs_pkg::S_VAR;
            bbrs_pkg::S_VAR:  n_state = bbrs_pkg::S_MAG;
            bbrs_pkg::S_MAG:  n_state = bbrs_pkg::S_M2;
            bbrs_pkg::S_M2:   n_state = bbrs_pkg::S_KVL;
            bbrs_pkg::S_KVL:  n_state = bbrs_pkg::S_KVH;
            bbrs_pkg::S_KVH:  n_state = bbrs_pkg::S_SUM;
            bbrs_pkg::S_SUM:  n_state = bbrs_pkg::S_DEC;
            bbrs_pkg::S_DEC:  if (out_free) n_state = bbrs_pkg::S_IDLE;
            default:          n_state = bbrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer outputs: handshake, ring commands and multiplier operands.
    always_comb begin
        o_ready         = (r_state == bbrs_pkg::S_IDLE);
        ring_ctrl.clear = i_cfg_we &&
                          (bbrs_pkg::t_cfg_index'(i_cfg_index) ==
                           bbrs_pkg::CFG_WINDOW_LENGTH);
        ring_ctrl.rd    = (r_state == bbrs_pkg::S_IDLE) && i_valid;
        ring_ctrl.adv   = (r_state == bbrs_pkg::S_OLD);
        load_out        = (r_state == bbrs_pkg::S_DEC) && out_free;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            bbrs_pkg::S_OLD: begin
                mul_a = bbrs_pkg::t_mul_op'(ring_rdata);
                mul_b = bbrs_pkg::t_mul_op'(ring_rdata);
            end
            bbrs_pkg::S_NEW: begin
                mul_a = bbrs_pkg::t_mul_op'(r_price);
                mul_b = bbrs_pkg::t_mul_op'(r_price);
            end
            bbrs_pkg::S_SQ: begin
                mul_a = bbrs_pkg::t_mul_op'(r_sum);
                mul_b = bbrs_pkg::t_mul_op'(r_sum);
            end
            bbrs_pkg::S_NQL: begin
                mul_a = bbrs_pkg::t_mul_op'(r_len);
                mul_b = r_sq[bbrs_pkg::MUL_W-1:0];
            end
            bbrs_pkg::S_NQH: begin
                mul_a = bbrs_pkg::t_mul_op'(r_len);
                mul_b = bbrs_pkg::t_mul_op'(r_sq[bbrs_pkg::SQ_W-1:bbrs_pkg::MUL_W]);
            end
            bbrs_pkg::S_NP: begin
                mul_a = bbrs_pkg::t_mul_op'(r_len);
                mul_b = bbrs_pkg::t_mul_op'(r_price);
            end
            bbrs_pkg::S_VAR: begin
                mul_a = bbrs_pkg::t_mul_op'(r_k);
                mul_b = bbrs_pkg::t_mul_op'(r_k);
            end
            bbrs_pkg::S_M2: begin
                mul_a = bbrs_pkg::t_mul_op'(r_mag);
                mul_b = bbrs_pkg::t_mul_op'(r_mag);
            end
            bbrs_pkg::S_KVL: begin
                mul_a = bbrs_pkg::t_mul_op'(r_k2);
                mul_b = r_var[bbrs_pkg::MUL_W-1:0];
            end
            bbrs_pkg::S_KVH: begin
                mul_a = bbrs_pkg::t_mul_op'(r_k2);
                mul_b = bbrs_pkg::t_mul_op'(r_var[bbrs_pkg::VAR_W-1:bbrs_pkg::MUL_W]);
            end
            default: ;
        endcase
    end

    // Band test: squared scaled deviation against k squared times variance.
    always_comb begin
        beyond    = (bbrs_pkg::RHS_W'({r_lhs, bbrs_pkg::KSHIFT'(0)}) > r_rhs);
        act       = bbrs_pkg::ACT_NONE;
        n_holding = r_holding;
        if (ring_stat.full) begin
            if (r_holding && r_above && beyond) begin
                act       = bbrs_pkg::ACT_EXIT;
                n_holding = 1'b0;
            end else if (!r_holding && r_below && beyond) begin
                act       = bbrs_pkg::ACT_ENTER;
                n_holding = 1'b1;
            end
        end
    end

    // Running sums; a window length write empties them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ring_ctrl.clear) begin
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            unique case (r_state)
                bbrs_pkg::S_OLD: begin
                    if (ring_stat.was_full) begin
                        r_sum <= r_sum - bbrs_pkg::t_sum'(ring_rdata);
                    end
                end
                bbrs_pkg::S_NEW: begin
                    r_sum <= r_sum + bbrs_pkg::t_sum'(r_price);
                    if (r_was_full) begin
                        r_sq <= r_sq - mul_p[bbrs_pkg::SQ_W-1:0];
                    end
                end
                bbrs_pkg::S_SQ: r_sq <= r_sq + mul_p[bbrs_pkg::SQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Position flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else if (load_out) begin
            r_holding <= n_holding;
        end
    end

    // Working registers of the band test.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price <= i_price_sample;
        end
        unique case (r_state)
            bbrs_pkg::S_OLD: r_was_full <= ring_stat.was_full;
            bbrs_pkg::S_NQL: r_ss  <= mul_p[bbrs_pkg::VAR_W-1:0];
            bbrs_pkg::S_NQH: r_var <= mul_p[bbrs_pkg::VAR_W-1:0];
            bbrs_pkg::S_NP: begin
                r_var <= r_var + {mul_p[bbrs_pkg::VAR_W-bbrs_pkg::MUL_W-1:0],
                                  bbrs_pkg::MUL_W'(0)};
            end
            bbrs_pkg::S_VAR: begin
                r_var <= r_var - r_ss;
                r_np  <= mul_p[bbrs_pkg::SUM_W-1:0];
            end
            bbrs_pkg::S_MAG: begin
                r_k2    <= mul_p[bbrs_pkg::K2_W-1:0];
                r_mag   <= (r_np >= r_sum) ? (r_np - r_sum) : (r_sum - r_np);
                r_above <= (r_np > r_sum);
                r_below <= (r_np < r_sum);
            end
            bbrs_pkg::S_KVL: r_lhs <= mul_p[bbrs_pkg::MAG2_W-1:0];
            bbrs_pkg::S_KVH: r_rhs <= bbrs_pkg::t_rhs'(mul_p);
            bbrs_pkg::S_SUM: begin
                r_rhs <= r_rhs + {mul_p[bbrs_pkg::RHS_W-bbrs_pkg::MUL_W-1:0],
                                  bbrs_pkg::MUL_W'(0)};
            end
            default: ;
        endcase
    end

    // Output register: a finished word waits here until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_action    <= act;
            r_out_full  <= ring_stat.full;
            r_out_held  <= n_holding;
            r_out_total <= r_sum;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_action;
    assign o_window_full   = r_out_full;
    assign o_position_held = r_out_held;
    assign o_window_total  = r_out_total;

endmodule

`default_nettype wire

>>> rtl/bbrs_checker.sv
// ============================================================================
// Bollinger band reversion signal checker
// Port-level checks of the result words and the one-word-at-a-time handshake.
// ============================================================================
`default_nettype none

`include "bollinger_band_reversion_signal_assert.svh"

module bbrs_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_ready,
    input wire                         o_valid,
    input wire                         i_ready,
    input wire [bbrs_pkg::ACT_W-1:0]   o_action,
    input wire                         o_window_full,
    input wire                         o_position_held,
    input wire [bbrs_pkg::SUM_W-1:0]   o_window_total
);

    logic                                       enter_word;
    logic                                       exit_word;
    logic                                       act_word;
    logic                                       held_match;
    logic                                       out_stall;
    logic [bbrs_pkg::ACT_W+bbrs_pkg::SUM_W+1:0] out_word;

    assign enter_word = o_valid && (o_action == bbrs_pkg::ACT_ENTER);
    assign exit_word  = o_valid && (o_action == bbrs_pkg::ACT_EXIT);
    assign act_word   = enter_word || exit_word;
    assign held_match = (o_position_held == enter_word);
    assign out_stall  = o_valid && !i_ready;
    assign out_word   = {o_action, o_window_full, o_position_held, o_window_total};

    // An entry leaves a position held and an exit leaves none.
    `BBRS_ASSERT_SAME(a_action_position, act_word, held_match, "position flag wrong")

    // No action is given before the window is full.
    `BBRS_ASSERT_SAME(a_action_needs_full, act_word, o_window_full, "action on a partial window")

    // The block works on one price at a time.
    `BBRS_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "price taken while busy")

    // A stalled result word holds.
    `BBRS_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(out_word), "stalled word changed")

endmodule

bind bollinger_band_reversion_signal bbrs_checker u_bbrs_checker (.*);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the Bollinger band reversion signal
// Streams price words through the block under several window lengths and
// band widths, predicts every result word with a cycle-free model of the
// band test, and checks each output word field by field in arrival order.
// ============================================================================

module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_HALF  = 115;
    localparam int PRICE_MAX   = 24'hFFFFFF;

    // One expected result word.
    typedef struct {
        bbrs_pkg::t_action          action;
        logic                       full;
        logic                       held;
        logic [bbrs_pkg::SUM_W-1:0] total;
    } t_signal_word;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    bbrs_pkg::t_cfg_index         i_cfg_index = bbrs_pkg::CFG_WINDOW_LENGTH;
    logic [bbrs_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [bbrs_pkg::PRICE_W-1:0] i_price_sample = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [bbrs_pkg::ACT_W-1:0]   o_action;
    logic                         o_window_full;
    logic                         o_position_held;
    logic [bbrs_pkg::SUM_W-1:0]   o_window_total;

    bollinger_band_reversion_signal u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_price_sample  (i_price_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_window_full   (o_window_full),
        .o_position_held (o_position_held),
        .o_window_total  (o_window_total)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [bbrs_pkg::PRICE_W-1:0] price_feed[$];
    t_signal_word                 expected_signals[$];
    int                           words_issued = 0;
    int                           words_checked = 0;
    int                           error_count = 0;
    int                           cycle_count = 0;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           walk_level = 0;
    int                           walk_amp = 1;

    // Model of the band test: ring of prices, running sums and position flag.
    logic [bbrs_pkg::PRICE_W-1:0] ring_prices[bbrs_pkg::MAX_WINDOW];
    logic [bbrs_pkg::PTR_W-1:0]   ring_ptr;
    bbrs_pkg::t_len               ring_fill;
    bbrs_pkg::t_sum               price_total;
    bbrs_pkg::t_sq                square_total;
    logic                         in_position;
    bbrs_pkg::t_len               win_len;
    logic [bbrs_pkg::K_W-1:0]     band_k;

    function automatic void empty_ring();
        ring_ptr     = '0;
        ring_fill    = '0;
        price_total  = '0;
        square_total = '0;
    endfunction

    function automatic void apply_setting(bbrs_pkg::t_cfg_index idx,
                                          logic [bbrs_pkg::CFG_W-1:0] data);
        bbrs_pkg::t_len len;
        if (idx == bbrs_pkg::CFG_WINDOW_LENGTH) begin
            // Only the low seven bits count; the value is clamped into range.
            len = data[bbrs_pkg::LEN_W-1:0];
            if (len < bbrs_pkg::MIN_WINDOW) len = bbrs_pkg::t_len'(bbrs_pkg::MIN_WINDOW);
            if (len > bbrs_pkg::MAX_WINDOW) len = bbrs_pkg::t_len'(bbrs_pkg::MAX_WINDOW);
            win_len = len;
            empty_ring();
        end else begin
            band_k = data[bbrs_pkg::K_W-1:0];
        end
    endfunction

    function automatic t_signal_word score_price(logic [bbrs_pkg::PRICE_W-1:0] price);
        t_signal_word                 w;
        int                           slot;
        logic [bbrs_pkg::PRICE_W-1:0] oldest;
        logic [63:0]                  np;
        logic [63:0]                  s;
        logic [63:0]                  spread;
        logic [63:0]                  mag;
        logic [127:0]                 lhs;
        logic [127:0]                 rhs;
        logic                         beyond;
        slot = int'(ring_ptr);
        if (slot >= int'(win_len)) slot = 0;
        if (ring_fill >= win_len) begin
            oldest       = ring_prices[slot];
            price_total  = price_total - bbrs_pkg::t_sum'(oldest);
            square_total = square_total - bbrs_pkg::t_sq'(64'(oldest) * 64'(oldest));
            ring_fill    = win_len;
        end else begin
            ring_fill = ring_fill + bbrs_pkg::t_len'(1);
        end
        ring_prices[slot] = price;
        price_total  = price_total + bbrs_pkg::t_sum'(price);
        square_total = square_total + bbrs_pkg::t_sq'(64'(price) * 64'(price));
        slot = slot + 1;
        ring_ptr = (slot >= int'(win_len)) ? '0 : bbrs_pkg::PTR_W'(slot);

        w.action = bbrs_pkg::ACT_NONE;
        if (ring_fill == win_len) begin
            // Squared band test: (256*D)^2 against K^2 * (n*Q - S*S).
            np     = 64'(win_len) * 64'(price);
            s      = 64'(price_total);
            spread = 64'(win_len) * 64'(square_total) - s * s;
            mag    = (np >= s) ? (np - s) : (s - np);
            lhs    = (128'(mag) << 8) * (128'(mag) << 8);
            rhs    = 128'(band_k) * 128'(band_k) * 128'(spread);
            beyond = (lhs > rhs);
            if (in_position && np > s && beyond) begin
                w.action    = bbrs_pkg::ACT_EXIT;
                in_position = 1'b0;
            end else if (!in_position && np < s && beyond) begin
                w.action    = bbrs_pkg::ACT_ENTER;
                in_position = 1'b1;
            end
        end
        w.full  = (ring_fill == win_len);
        w.held  = in_position;
        w.total = price_total;
        return w;
    endfunction

    // Track register writes and accepted price words in the model.
    always @(posedge i_clk) begin
        t_signal_word got;
        if (!i_rst_n) begin
            win_len     = bbrs_pkg::WINDOW_LENGTH_RESET;
            band_k      = bbrs_pkg::BAND_WIDTH_K_RESET;
            in_position = 1'b0;
            empty_ring();
        end else begin
            if (i_cfg_we) apply_setting(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) begin
                got              = score_price(i_price_sample);
                expected_signals = {expected_signals, got};
            end
        end
    end

    // Driver: present the next queued price, holding it until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_ready) begin
            // Word still waiting; keep valid and payload as they are.
        end else if (price_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            i_valid        <= 1'b1;
            i_price_sample <= price_feed[0];
            price_feed.delete(0);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_signal_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_signals.size() == 0) begin
                $display("%0t: result word with nothing expected (action %0d total %0d)",
                         $time, o_action, o_window_total);
                error_count++;
            end else begin
                want = expected_signals[0];
                expected_signals.delete(0);
                if (o_action !== want.action) begin
                    $display("%0t: action expected %0d got %0d", $time, want.action, o_action);
                    error_count++;
                end
                if (o_window_full !== want.full) begin
                    $display("%0t: window_full expected %0d got %0d",
                             $time, want.full, o_window_full);
                    error_count++;
                end
                if (o_position_held !== want.held) begin
                    $display("%0t: position_held expected %0d got %0d",
                             $time, want.held, o_position_held);
                    error_count++;
                end
                if (o_window_total !== want.total) begin
                    $display("%0t: window_total expected %0d got %0d",
                             $time, want.total, o_window_total);
                    error_count++;
                end
            end
            words_checked++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_price(logic [bbrs_pkg::PRICE_W-1:0] price);
        price_feed = {price_feed, price};
        words_issued++;
    endtask

    // Hold off until every word sent so far has come back.
    task automatic wait_drained();
        while (words_checked < words_issued) @(posedge i_clk);
    endtask

    task automatic write_setting(bbrs_pkg::t_cfg_index idx, logic [bbrs_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random walk of prices with spikes, jumps and some raw noise.
    function automatic logic [bbrs_pkg::PRICE_W-1:0] next_quote();
        int r;
        int step;
        r = $urandom_range(0, 99);
        if (r < 4) return bbrs_pkg::PRICE_W'($urandom);
        if (r < 7) return ($urandom_range(0, 1) != 0) ? bbrs_pkg::PRICE_W'(PRICE_MAX) : '0;
        if (r < 9) walk_level = $urandom_range(0, PRICE_MAX);
        if (r < 22) begin
            step = int'($urandom_range(3, 8)) * walk_amp;
            if ($urandom_range(0, 1) != 0) step = -step;
        end else begin
            step = int'($urandom_range(0, 2 * walk_amp)) - walk_amp;
        end
        walk_level = walk_level + step;
        if (walk_level < 0) walk_level = 0;
        if (walk_level > PRICE_MAX) walk_level = PRICE_MAX;
        return bbrs_pkg::PRICE_W'(walk_level);
    endfunction

    initial begin
        logic [bbrs_pkg::CFG_W-1:0] len_data;
        logic [bbrs_pkg::CFG_W-1:0] k_data;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a few words under reset settings, window not yet full.
        queue_price(24'hFFFFFF);
        queue_price(24'h000000);
        queue_price(24'hABCDEF);
        wait_drained();

        // Length below the minimum, zero k: extremes, entry, exit, flat window.
        write_setting(bbrs_pkg::CFG_WINDOW_LENGTH, 12'd1);
        write_setting(bbrs_pkg::CFG_BAND_WIDTH_K, 12'd0);
        queue_price(24'h000000);
        queue_price(24'hFFFFFF);
        queue_price(24'h000000);
        queue_price(24'hFFFFFF);
        queue_price(24'd7);
        queue_price(24'd7);
        queue_price(24'd6);
        wait_drained();

        // Rewriting the length empties the window but keeps the position.
        write_setting(bbrs_pkg::CFG_WINDOW_LENGTH, 12'd2);
        queue_price(24'd9);
        queue_price(24'd9);
        queue_price(24'd20);
        wait_drained();

        // Widest band, window kept across the write.
        write_setting(bbrs_pkg::CFG_BAND_WIDTH_K, 12'hFFF);
        queue_price(24'd9);
        queue_price(24'h000000);
        queue_price(24'hFFFFFF);
        wait_drained();

        // Upper data bits ignored: length three, k of one.
        write_setting(bbrs_pkg::CFG_WINDOW_LENGTH, 12'hF83);
        write_setting(bbrs_pkg::CFG_BAND_WIDTH_K, 12'd256);
        queue_price(24'd100);
        queue_price(24'd100);
        queue_price(24'd100);
        queue_price(24'd99);
        queue_price(24'hFFFFFF);

        // Random phases over settings and idling patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            unique case (ph)
                0: begin len_data = 12'd2;  k_data = 12'd0;    end
                1: begin len_data = 12'd64; k_data = 12'hFFF;  end
                2: begin len_data = 12'd65; k_data = 12'd512;  end
                3: begin len_data = 12'd0;  k_data = 12'd256;  end
                default: begin
                    len_data = {5'($urandom), ($urandom_range(0, 1) != 0) ?
                                7'($urandom_range(2, 16)) : 7'($urandom_range(0, 127))};
                    k_data = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 767))
                                                         : 12'($urandom_range(0, 4095));
                end
            endcase
            write_setting(bbrs_pkg::CFG_WINDOW_LENGTH, len_data);
            write_setting(bbrs_pkg::CFG_BAND_WIDTH_K, k_data);
            unique case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            walk_level = $urandom_range(0, PRICE_MAX);
            walk_amp   = 1 << $urandom_range(0, 18);
            repeat (PHASE_HALF) queue_price(next_quote());
            // Sender pauses until all results are back, then k changes mid-stream.
            wait_drained();
            write_setting(bbrs_pkg::CFG_BAND_WIDTH_K, ($urandom_range(0, 1) != 0) ?
                          12'($urandom_range(0, 767)) : 12'($urandom));
            repeat (PHASE_HALF) queue_price(next_quote());
        end

        wait_drained();
        repeat (24) @(posedge i_clk);
        if (error_count == 0 && expected_signals.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bbrs_pkg.sv
rtl/bbrs_mul.sv
rtl/bbrs_ring.sv
rtl/bollinger_band_reversion_signal.sv
rtl/bbrs_checker.sv
dv/tb.sv
